[sv/word_frequency_table_assert.svh]
// Assertion macros for the word frequency table checker.
// Needs signals clock and reset in the scope of use.
`ifndef WORD_FREQUENCY_TABLE_ASSERT_SVH
`define WORD_FREQUENCY_TABLE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WFT_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("word_frequency_table: assertion failed");

// Next-cycle implication, checked outside reset.
`define WFT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("word_frequency_table: assertion failed");

`endif

[sv/wft_pkg.sv]
// Shared types and constants for the word frequency table.
// No dependencies.
package wft_pkg;

   localparam logic [1:0] FUNC_BYTE  = 2'd0;
   localparam logic [1:0] FUNC_FLUSH = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   localparam logic [1:0] STATUS_LETTER  = 2'd0;
   localparam logic [1:0] STATUS_SUMMARY = 2'd1;
   localparam logic [1:0] STATUS_BAD_IDX = 2'd2;

   localparam logic [7:0] CHAR_UP_A = 8'd65;
   localparam logic [7:0] CHAR_UP_Z = 8'd90;
   localparam logic [7:0] CHAR_LO_A = 8'd97;
   localparam logic [7:0] CHAR_LO_Z = 8'd122;
   localparam logic [7:0] CHAR_TAB  = 8'd9;
   localparam logic [7:0] CHAR_CR   = 8'd13;
   localparam logic [7:0] CHAR_SP   = 8'd32;

   localparam logic [19:0] COUNT_MAX = 20'hFFFFF;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] text_byte;
      logic [6:0] entry_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  letter;
      logic [19:0] word_count;
      logic [7:0]  distinct_words;
      logic        table_overflow;
      logic        last;
   } rsp_type;

endpackage

[sv/wft_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module wft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

[sv/word_frequency_table.sv]
// Word frequency table: top level with sequencer and entry memories.
// Depends on wft_pkg and wft_ram.
//
// A letter or other byte that ends no word is taken in the idle state. A whitespace byte that
// ends a word walks the stored entries through single-port memories, comparing lengths and
// then letters, then bumps the matching count or appends a new entry. End of text runs a
// selection sort over an index table, comparing entries by letter and then by length, then
// offers one summary result. A read looks up the index table, then offers one result per
// letter, each held until rsp_ready. The block takes one transaction at a time and holds
// req_ready low until its results are all taken.
module word_frequency_table #(
   parameter int ENTRIES     = 128,
   parameter int MAX_LETTERS = 30
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  wft_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output wft_pkg::rsp_type rsp_data
);
   import wft_pkg::*;

   localparam int EW  = $clog2(ENTRIES);
   localparam int CW  = $clog2(ENTRIES + 1);
   localparam int LW  = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;
   localparam int TLW = $clog2(MAX_LETTERS + 1);
   localparam int STORE_DEPTH = ENTRIES * (1 << LW);

   typedef enum logic [4:0] {
      S_IDLE, S_LOOK, S_LEN_CHK, S_LET_RD, S_LET_CHK, S_CNT_RD, S_CNT_WR, S_MISS,
      S_APPEND, S_WORD_END, S_SORT_TOP, S_SORT_B0, S_SORT_PI, S_SORT_CAND, S_SORT_LA,
      S_SORT_LB, S_SORT_RA, S_SORT_RB, S_SORT_CMP, S_SWAP_CHK, S_SWAP_RD, S_SWAP_WR,
      S_SUMMARY, S_RD_PERM, S_RD_SLOT, S_RD_INFO, S_RD_LET, S_RD_EMIT, S_WAIT
   } state_type;

   state_type        state_ff;
   logic [1:0]       func_ff;
   logic [6:0]       idx_ff;
   logic [4:0]       tok_ff [MAX_LETTERS];
   logic [TLW-1:0]   tok_len_ff;
   logic [CW-1:0]    used_ff;
   logic             ovf_ff;
   logic [CW-1:0]    e_ff;
   logic [TLW-1:0]   i_ff;
   logic [CW-1:0]    top_ff;
   logic [CW-1:0]    pos_ff;
   logic [CW-1:0]    bpos_ff;
   logic [EW-1:0]    bslot_ff;
   logic [EW-1:0]    cslot_ff;
   logic [EW-1:0]    slot_ff;
   logic [TLW-1:0]   la_ff;
   logic [TLW-1:0]   lb_ff;
   logic [4:0]       let_ff;
   logic [19:0]      cnt_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   logic [EW-1:0]    st_slot;
   logic [LW-1:0]    st_pos;
   logic             st_we;
   logic [4:0]       st_wd;
   logic [4:0]       st_rd;
   logic [EW-1:0]    ln_addr;
   logic             ln_we;
   logic [TLW-1:0]   ln_rd;
   logic [EW-1:0]    ct_addr;
   logic             ct_we;
   logic [19:0]      ct_wd;
   logic [19:0]      ct_rd;
   logic [EW-1:0]    pm_addr;
   logic             pm_we;
   logic [EW-1:0]    pm_wd;
   logic [EW-1:0]    pm_rd;

   logic [CW-1:0]    top_m1;
   logic [TLW-1:0]   min_len;
   logic             sort_done;
   logic             sort_after;
   logic             is_space;
   logic             is_upper;
   logic             is_lower;
   logic [7:0]       letter_code;
   logic [31:0]      used_wide;
   logic             idx_bad;

   assign top_m1   = top_ff - CW'(1);
   assign min_len  = (la_ff < lb_ff) ? la_ff : lb_ff;
   assign sort_done = ((state_ff == S_SORT_RA) && (i_ff == min_len)) ||
                      ((state_ff == S_SORT_CMP) && (let_ff != st_rd));
   assign sort_after = (state_ff == S_SORT_RA) ? (la_ff > lb_ff) : (let_ff > st_rd);

   assign is_space = ((req_data.text_byte >= CHAR_TAB) && (req_data.text_byte <= CHAR_CR)) ||
                     (req_data.text_byte == CHAR_SP);
   assign is_upper = (req_data.text_byte >= CHAR_UP_A) && (req_data.text_byte <= CHAR_UP_Z);
   assign is_lower = (req_data.text_byte >= CHAR_LO_A) && (req_data.text_byte <= CHAR_LO_Z);
   assign letter_code = is_upper ? (req_data.text_byte - CHAR_UP_A)
                                 : (req_data.text_byte - CHAR_LO_A);
   assign used_wide = 32'(used_ff);
   assign idx_bad   = (32'(req_data.entry_index) >= used_wide) ||
                      (32'(req_data.entry_index) >= 32'(ENTRIES));

   always_comb begin
      st_slot = e_ff[EW-1:0];
      st_pos  = i_ff[LW-1:0];
      st_we   = 1'b0;
      st_wd   = tok_ff[i_ff[LW-1:0]];
      ln_addr = e_ff[EW-1:0];
      ln_we   = 1'b0;
      ct_addr = e_ff[EW-1:0];
      ct_we   = 1'b0;
      ct_wd   = (ct_rd == COUNT_MAX) ? ct_rd : (ct_rd + 20'd1);
      pm_addr = pos_ff[EW-1:0];
      pm_we   = 1'b0;
      pm_wd   = used_ff[EW-1:0];
      unique case (state_ff)
         S_CNT_WR: begin
            ct_we = 1'b1;
         end
         S_APPEND: begin
            st_slot = used_ff[EW-1:0];
            st_we   = 1'b1;
            ln_addr = used_ff[EW-1:0];
            ln_we   = 1'b1;
            ct_addr = used_ff[EW-1:0];
            ct_we   = 1'b1;
            ct_wd   = 20'd1;
            pm_addr = used_ff[EW-1:0];
            pm_we   = 1'b1;
         end
         S_SORT_TOP: begin
            pm_addr = '0;
         end
         S_SORT_CAND: begin
            ln_addr = pm_rd;
         end
         S_SORT_LA: begin
            ln_addr = bslot_ff;
         end
         S_SORT_RA: begin
            st_slot = cslot_ff;
         end
         S_SORT_RB: begin
            st_slot = bslot_ff;
         end
         S_SWAP_CHK: begin
            pm_addr = top_m1[EW-1:0];
         end
         S_SWAP_RD: begin
            pm_addr = bpos_ff[EW-1:0];
            pm_we   = 1'b1;
            pm_wd   = pm_rd;
         end
         S_SWAP_WR: begin
            pm_addr = top_m1[EW-1:0];
            pm_we   = 1'b1;
            pm_wd   = bslot_ff;
         end
         S_RD_PERM: begin
            pm_addr = EW'(idx_ff);
         end
         S_RD_SLOT: begin
            ln_addr = pm_rd;
            ct_addr = pm_rd;
         end
         S_RD_LET: begin
            st_slot = slot_ff;
         end
         default: begin
         end
      endcase
   end

   wft_ram #(.WIDTH(5), .DEPTH(STORE_DEPTH)) u_store (
      .clock(clock), .we(st_we), .addr({st_slot, st_pos}), .wdata(st_wd), .rdata(st_rd)
   );
   wft_ram #(.WIDTH(TLW), .DEPTH(ENTRIES)) u_len (
      .clock(clock), .we(ln_we), .addr(ln_addr), .wdata(tok_len_ff), .rdata(ln_rd)
   );
   wft_ram #(.WIDTH(20), .DEPTH(ENTRIES)) u_cnt (
      .clock(clock), .we(ct_we), .addr(ct_addr), .wdata(ct_wd), .rdata(ct_rd)
   );
   wft_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_perm (
      .clock(clock), .we(pm_we), .addr(pm_addr), .wdata(pm_wd), .rdata(pm_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tok_len_ff   <= '0;
         used_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  func_ff <= req_data.func;
                  idx_ff  <= req_data.entry_index;
                  e_ff    <= '0;
                  top_ff  <= used_ff;
                  unique case (req_data.func)
                     FUNC_BYTE: begin
                        if (is_space) begin
                           if (tok_len_ff != '0) begin
                              state_ff <= S_LOOK;
                           end
                        end else if ((is_upper || is_lower) &&
                                     (32'(tok_len_ff) < 32'(MAX_LETTERS))) begin
                           tok_ff[tok_len_ff[LW-1:0]] <= letter_code[4:0];
                           tok_len_ff <= tok_len_ff + TLW'(1);
                        end
                     end
                     FUNC_FLUSH: begin
                        state_ff <= (tok_len_ff != '0) ? S_LOOK : S_SORT_TOP;
                     end
                     FUNC_READ: begin
                        if (idx_bad) begin
                           rsp_ff.status     <= STATUS_BAD_IDX;
                           rsp_ff.letter     <= '0;
                           rsp_ff.word_count <= '0;
                           rsp_ff.distinct_words <= used_wide[7:0];
                           rsp_ff.table_overflow <= ovf_ff;
                           rsp_ff.last       <= 1'b1;
                           rsp_valid_ff      <= 1'b1;
                           state_ff          <= S_WAIT;
                        end else begin
                           state_ff <= S_RD_PERM;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_LOOK: begin
               state_ff <= (e_ff == used_ff) ? S_MISS : S_LEN_CHK;
            end
            S_LEN_CHK: begin
               i_ff <= '0;
               if (ln_rd == tok_len_ff) begin
                  state_ff <= S_LET_RD;
               end else begin
                  e_ff     <= e_ff + CW'(1);
                  state_ff <= S_LOOK;
               end
            end
            S_LET_RD: begin
               state_ff <= S_LET_CHK;
            end
            S_LET_CHK: begin
               if (st_rd != tok_ff[i_ff[LW-1:0]]) begin
                  e_ff     <= e_ff + CW'(1);
                  state_ff <= S_LOOK;
               end else if ((i_ff + TLW'(1)) == tok_len_ff) begin
                  state_ff <= S_CNT_RD;
               end else begin
                  i_ff     <= i_ff + TLW'(1);
                  state_ff <= S_LET_RD;
               end
            end
            S_CNT_RD: begin
               state_ff <= S_CNT_WR;
            end
            S_CNT_WR: begin
               state_ff <= S_WORD_END;
            end
            S_MISS: begin
               i_ff <= '0;
               if (32'(used_ff) < 32'(ENTRIES)) begin
                  state_ff <= S_APPEND;
               end else begin
                  ovf_ff   <= 1'b1;
                  state_ff <= S_WORD_END;
               end
            end
            S_APPEND: begin
               if ((i_ff + TLW'(1)) == tok_len_ff) begin
                  used_ff  <= used_ff + CW'(1);
                  state_ff <= S_WORD_END;
               end else begin
                  i_ff <= i_ff + TLW'(1);
               end
            end
            S_WORD_END: begin
               tok_len_ff <= '0;
               top_ff     <= used_ff;
               state_ff   <= (func_ff == FUNC_FLUSH) ? S_SORT_TOP : S_IDLE;
            end
            S_SORT_TOP: begin
               pos_ff  <= CW'(1);
               bpos_ff <= '0;
               state_ff <= (top_ff <= CW'(1)) ? S_SUMMARY : S_SORT_B0;
            end
            S_SORT_B0: begin
               bslot_ff <= pm_rd;
               state_ff <= S_SORT_PI;
            end
            S_SORT_PI: begin
               state_ff <= (pos_ff == top_ff) ? S_SWAP_CHK : S_SORT_CAND;
            end
            S_SORT_CAND: begin
               cslot_ff <= pm_rd;
               state_ff <= S_SORT_LA;
            end
            S_SORT_LA: begin
               la_ff    <= ln_rd;
               state_ff <= S_SORT_LB;
            end
            S_SORT_LB: begin
               lb_ff    <= ln_rd;
               i_ff     <= '0;
               state_ff <= S_SORT_RA;
            end
            S_SORT_RA, S_SORT_CMP: begin
               if (sort_done) begin
                  if (sort_after) begin
                     bpos_ff  <= pos_ff;
                     bslot_ff <= cslot_ff;
                  end
                  pos_ff   <= pos_ff + CW'(1);
                  state_ff <= S_SORT_PI;
               end else if (state_ff == S_SORT_RA) begin
                  state_ff <= S_SORT_RB;
               end else begin
                  i_ff     <= i_ff + TLW'(1);
                  state_ff <= S_SORT_RA;
               end
            end
            S_SORT_RB: begin
               let_ff   <= st_rd;
               state_ff <= S_SORT_CMP;
            end
            S_SWAP_CHK: begin
               if (bpos_ff == top_m1) begin
                  top_ff   <= top_m1;
                  state_ff <= S_SORT_TOP;
               end else begin
                  state_ff <= S_SWAP_RD;
               end
            end
            S_SWAP_RD: begin
               state_ff <= S_SWAP_WR;
            end
            S_SWAP_WR: begin
               top_ff   <= top_m1;
               state_ff <= S_SORT_TOP;
            end
            S_SUMMARY: begin
               rsp_ff.status     <= STATUS_SUMMARY;
               rsp_ff.letter     <= '0;
               rsp_ff.word_count <= '0;
               rsp_ff.distinct_words <= used_wide[7:0];
               rsp_ff.table_overflow <= ovf_ff;
               rsp_ff.last       <= 1'b1;
               rsp_valid_ff      <= 1'b1;
               state_ff          <= S_WAIT;
            end
            S_RD_PERM: begin
               state_ff <= S_RD_SLOT;
            end
            S_RD_SLOT: begin
               slot_ff  <= pm_rd;
               i_ff     <= '0;
               state_ff <= S_RD_INFO;
            end
            S_RD_INFO: begin
               la_ff    <= ln_rd;
               cnt_ff   <= ct_rd;
               state_ff <= S_RD_LET;
            end
            S_RD_LET: begin
               state_ff <= S_RD_EMIT;
            end
            S_RD_EMIT: begin
               rsp_ff.status     <= STATUS_LETTER;
               rsp_ff.letter     <= CHAR_LO_A + {3'b000, st_rd};
               rsp_ff.word_count <= cnt_ff;
               rsp_ff.distinct_words <= used_wide[7:0];
               rsp_ff.table_overflow <= ovf_ff;
               rsp_ff.last       <= ((i_ff + TLW'(1)) == la_ff);
               rsp_valid_ff      <= 1'b1;
               state_ff          <= S_WAIT;
            end
            S_WAIT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  i_ff         <= i_ff + TLW'(1);
                  state_ff     <= rsp_ff.last ? S_IDLE : S_RD_LET;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

[sv/wft_checker.sv]
// Port-level checker for the word frequency table, bound to the top level.
// Depends on wft_pkg and word_frequency_table_assert.svh.
`include "word_frequency_table_assert.svh"

module wft_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input wft_pkg::rsp_type rsp_data
);
   import wft_pkg::*;

   logic single_rsp;

   assign single_rsp = rsp_valid && (rsp_data.status != STATUS_LETTER);

   `WFT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `WFT_ASSERT_NOW(a_busy_when_rsp, rsp_valid, !req_ready)
   `WFT_ASSERT_NOW(a_single_last, single_rsp, rsp_data.last)
   `WFT_ASSERT_NOW(a_single_blank, single_rsp, (rsp_data.letter == '0) && (rsp_data.word_count == '0))
endmodule

bind word_frequency_table wft_checker u_wft_checker (.*);
